@@ src/tma_pkg.sv @@
package tma_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned RPM_W = 16;
  localparam logic [RPM_W-1:0] RPM_PER_MS = 16'd60000;
  localparam logic [RPM_W-1:0] RPM_MAX = 16'd60000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RPM,
    ST_SUM,
    ST_MEAN,
    ST_OUT
  } tma_state_t;

endpackage

@@ src/tma_serial_div.sv @@
// Restoring divider, one quotient bit per cycle. The dividend register
// shifts out its top bit into the partial remainder and takes the quotient
// bit at the bottom, so once all DVD_W dividend bits have shifted out it holds the quotient.
module tma_serial_div #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned DVR_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] shreg;
  logic [DVR_W-1:0] rem;
  logic [DVR_W-1:0] dvr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVR_W:0]   trial;
  logic [DVR_W:0]   diff;
  logic             ge;

  assign trial = {rem, shreg[DVD_W-1]};
  assign ge = trial >= {1'b0, dvr};
  assign diff = trial - {1'b0, dvr};
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvr   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[DVD_W-2:0], ge};
      rem   <= ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
    end
  end

endmodule

@@ src/tachometer_moving_average_rpm.sv @@
// Revolution tachometer with a moving-average output. Each input item is
// the millisecond timestamp of one revolution pulse; each item gives one
// result with this revolution's RPM, floor(60000 / elapsed) saturated at
// 60000 when two pulses share a timestamp, and the truncated mean of the
// last WINDOW values (entries not yet written count as zero). The first
// pulse measures from timestamp zero. One item is in work at a time and
// passes, before the next can be accepted, through a bit-serial period
// divider, a ring and sum update, and a bit-serial mean divider over a
// dividend of 16 + clog2(WINDOW) bits. The next item is taken while a
// finished result still waits in the output register.
module tachometer_moving_average_rpm
  import tma_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] pulse_time_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [15:0] rev_rpm, [31:16] mean_rpm
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SUM_W = RPM_W + $clog2(WINDOW);
  localparam int unsigned WDV_W = $clog2(WINDOW + 1);

  tma_state_t state, state_next;

  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] elapsed;
  logic              period_zero;
  logic              period_big;
  logic [RPM_W-1:0]  rpm;
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  window_sum;
  logic [SUM_W-1:0]  sum_next;
  logic [RPM_W-1:0]  ring [WINDOW];
  logic [WINDOW-1:0] ring_valid;
  logic [RPM_W-1:0]  old_rpm;
  logic              old_valid;
  logic [RPM_W-1:0]  old_val;

  logic              in_accept;
  logic              out_free;
  logic              rpm_start, rpm_done;
  logic [RPM_W-1:0]  rpm_quot;
  logic              mean_start, mean_done;
  logic [SUM_W-1:0]  mean_quot;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign elapsed = s_axis_tdata - last_time;
  assign old_val = old_valid ? old_rpm : '0;
  assign sum_next = window_sum - SUM_W'(old_val) + SUM_W'(rpm);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_axis_tready = 1'b0;
    rpm_start = 1'b0;
    mean_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          rpm_start = 1'b1;
          state_next = ST_RPM;
        end
      end
      ST_RPM: begin
        if (rpm_done) state_next = ST_SUM;
      end
      ST_SUM: begin
        mean_start = 1'b1;
        state_next = ST_MEAN;
      end
      ST_MEAN: begin
        if (mean_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: timestamp, write slot, running sum, valid bits, output.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time     <= '0;
      slot          <= '0;
      window_sum    <= '0;
      ring_valid    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_accept) last_time <= s_axis_tdata;
      if (state == ST_SUM) begin
        window_sum       <= sum_next;
        ring_valid[slot] <= 1'b1;
        slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      end
      if (state == ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      period_zero <= elapsed == '0;
      period_big  <= elapsed[TIME_W-1:RPM_W] != '0;
      old_valid   <= ring_valid[slot];
    end
    // A period of 2^16 ms or more is beyond 60000 and gives zero.
    if (state == ST_RPM && rpm_done) begin
      rpm <= period_zero ? RPM_MAX : (period_big ? '0 : rpm_quot);
    end
    if (state == ST_OUT && out_free) begin
      m_axis_tdata <= {mean_quot[RPM_W-1:0], rpm};
    end
  end

  // Ring storage: read the entry to replace at acceptance, write it back later.
  always_ff @(posedge clk) begin
    if (in_accept) old_rpm <= ring[slot];
    if (state == ST_SUM) ring[slot] <= rpm;
  end

  tma_serial_div #(
    .DVD_W(RPM_W),
    .DVR_W(RPM_W)
  ) u_rpm_div (
    .clk      (clk),
    .rst      (rst),
    .start    (rpm_start),
    .dividend (RPM_PER_MS),
    .divisor  (elapsed[RPM_W-1:0]),
    .done     (rpm_done),
    .quotient (rpm_quot)
  );

  tma_serial_div #(
    .DVD_W(SUM_W),
    .DVR_W(WDV_W)
  ) u_mean_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mean_start),
    .dividend (sum_next),
    .divisor  (WDV_W'(WINDOW)),
    .done     (mean_done),
    .quotient (mean_quot)
  );

endmodule

@@ src/tma_port_checker.sv @@
module tma_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Hold a stalled result item.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_rev_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'd60000)
    else $error("rev_rpm above 60000");

  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:16] <= 16'd60000)
    else $error("mean_rpm above 60000");

  // One item in work at a time: drop ready right after acceptance.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input item accepted while another is in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result item presented after reset");

endmodule

bind tachometer_moving_average_rpm tma_port_checker u_port_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb_tachometer_moving_average_rpm.sv @@
`timescale 1ns / 100ps

module tb_tachometer_moving_average_rpm;
  import tma_pkg::*;

  localparam int unsigned WINDOW = 64;
  localparam int unsigned SUM_W = 24;
  localparam int unsigned RANDOM_PULSES = 1425;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [RPM_W-1:0] rev_rpm;
    logic [RPM_W-1:0] mean_rpm;
  } rpm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] pulse_time_ms
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [15:0] rev_rpm, [31:16] mean_rpm

  // Shadow copy of the tachometer state
  logic [TIME_W-1:0] prev_stamp = '0;
  logic [RPM_W-1:0]  rpm_ring [WINDOW] = '{default: '0};
  int unsigned       ring_slot = 0;
  logic [SUM_W-1:0]  rpm_sum = '0;

  logic [TIME_W-1:0] pulse_q [$];
  rpm_result_t       rpm_expect_q [$];
  logic [TIME_W-1:0] stamp_now = '0;

  int unsigned pulses_total = 0;
  int unsigned pulses_issued = 0;
  int unsigned pulses_taken = 0;
  int unsigned results_checked = 0;
  int unsigned sat_count = 0;
  int unsigned zero_count = 0;
  int unsigned ring_wraps = 0;
  int unsigned fail_count = 0;
  int unsigned src_idle = 0;
  int unsigned sink_stall = 0;
  int unsigned sink_calm = 0;

  tachometer_moving_average_rpm #(
    .WINDOW(WINDOW)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned draw_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(5, 80);
  endfunction

  task automatic push_elapsed(input logic [TIME_W-1:0] delta);
    stamp_now = stamp_now + delta;
    pulse_q.push_back(stamp_now);
  endtask

  task automatic push_stamp(input logic [TIME_W-1:0] stamp);
    stamp_now = stamp;
    pulse_q.push_back(stamp_now);
  endtask

  // Advance the shadow state by one pulse and queue the result it yields
  task automatic tacho_predict(input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] rpm32;
    rpm_result_t       res;
    elapsed = stamp - prev_stamp;
    if (elapsed == '0) begin
      rpm32 = TIME_W'(RPM_MAX);
      sat_count++;
    end else begin
      rpm32 = TIME_W'(RPM_PER_MS) / elapsed;
    end
    if (rpm32 == '0) zero_count++;
    prev_stamp = stamp;
    rpm_sum = rpm_sum - SUM_W'(rpm_ring[ring_slot]) + SUM_W'(rpm32[RPM_W-1:0]);
    rpm_ring[ring_slot] = rpm32[RPM_W-1:0];
    if (ring_slot == WINDOW - 1) begin
      ring_slot = 0;
      ring_wraps++;
    end else begin
      ring_slot++;
    end
    res.rev_rpm = rpm32[RPM_W-1:0];
    res.mean_rpm = RPM_W'(rpm_sum / WINDOW);
    rpm_expect_q.push_back(res);
  endtask

  // Source side: hold an offered item until taken, then idle or offer the next
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && pulses_issued != pulses_taken)) begin
      if (src_idle > 0) begin
        s_axis_tvalid <= 1'b0;
        src_idle--;
      end else if (pulse_q.size() > 0) begin
        s_axis_tdata <= pulse_q.pop_front();
        s_axis_tvalid <= 1'b1;
        pulses_issued++;
        src_idle = draw_idle();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      tacho_predict(s_axis_tdata);
      pulses_taken++;
    end
  end

  // Sink side: random stalls with occasional calm stretches
  always @(negedge clk) begin
    logic ready_next;
    ready_next = 1'b1;
    if (sink_stall > 0) begin
      ready_next = 1'b0;
      sink_stall--;
    end else if (sink_calm > 0) begin
      sink_calm--;
    end else if ($urandom_range(0, 499) == 0) begin
      sink_calm = $urandom_range(200, 2000);
    end else if ($urandom_range(0, 5) == 0) begin
      sink_stall = draw_idle();
      if (sink_stall > 0) begin
        ready_next = 1'b0;
        sink_stall--;
      end
    end
    m_axis_tready <= ready_next;
  end

  always @(posedge clk) begin
    rpm_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rpm_expect_q.size() == 0) begin
        $error("unexpected result item: rev_rpm %0d, mean_rpm %0d",
               m_axis_tdata[15:0], m_axis_tdata[31:16]);
        fail_count++;
      end else begin
        want = rpm_expect_q.pop_front();
        if (m_axis_tdata[15:0] !== want.rev_rpm) begin
          $error("rev_rpm mismatch: expected %0d, actual %0d",
                 want.rev_rpm, m_axis_tdata[15:0]);
          fail_count++;
        end
        if (m_axis_tdata[31:16] !== want.mean_rpm) begin
          $error("mean_rpm mismatch: expected %0d, actual %0d",
                 want.mean_rpm, m_axis_tdata[31:16]);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d of %0d pulses taken, %0d results pending",
             pulses_taken, pulses_total, rpm_expect_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned run_len;
    int unsigned base;
    int unsigned n;
    int unsigned jit;

    // Directed: first pulse from zero, equal stamps, divider edges, wrap
    push_elapsed(0);
    push_elapsed(0);
    push_elapsed(1);
    push_elapsed(2);
    push_elapsed(7);
    push_elapsed(59999);
    push_elapsed(60000);
    push_elapsed(60001);
    push_stamp(32'hFFFF_FFFF);
    push_stamp(32'hFFFF_FFFF);
    push_stamp(32'h0000_0004);
    push_stamp(32'hFFFF_FFF0);
    push_stamp(32'h0000_0010);
    push_elapsed(3);
    push_elapsed(32'h8000_0000);
    push_elapsed(32'hFFFF_FFFF);
    push_stamp(32'h0000_0000);
    push_elapsed(30001);
    push_elapsed(40);

    n = 0;
    while (n < RANDOM_PULSES) begin
      mode = $urandom_range(0, 99);
      if (mode < 50) begin
        // steady spin with a little jitter
        run_len = $urandom_range(1, 100);
        base = $urandom_range(3, 200);
        for (int i = 0; i < run_len; i++) begin
          jit = $urandom_range(0, 4);
          push_elapsed(base + jit - 2);
        end
      end else if (mode < 65) begin
        // pulses closer than one tick: saturate the window
        run_len = $urandom_range(40, 90);
        for (int i = 0; i < run_len; i++) push_elapsed($urandom_range(0, 1));
      end else if (mode < 80) begin
        // slow or stopped shaft
        run_len = $urandom_range(1, 80);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 1) == 0) push_elapsed($urandom_range(1000, 70000));
          else push_elapsed($urandom_range(60001, 200000));
        end
      end else begin
        // noise: arbitrary stamps and arbitrary periods
        run_len = $urandom_range(1, 20);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 1) == 0) push_stamp($urandom());
          else push_elapsed($urandom());
        end
      end
      n += run_len;
    end
    pulses_total = pulse_q.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pulses_taken < pulses_total || rpm_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pulses, %0d results checked, %0d ring wraps",
             pulses_taken, results_checked, ring_wraps);
    $display("%0d saturated periods, %0d periods too long for one rpm",
             sat_count, zero_count);
    if (fail_count == 0 && rpm_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
